FILE: rtl/core/psg_pkg.sv
// Shared types, constants and gain table for the tone and noise generator.
package psg_pkg;

    localparam int unsigned BaseW      = 36;
    localparam int unsigned StepW      = 32;
    localparam int unsigned SampleW    = 11;
    localparam int unsigned FifoDepth  = 4;
    localparam logic [BaseW-1:0] BaseReset = 36'd10794924905;
    localparam logic [14:0] LfsrSeed   = 15'h4000;
    localparam logic OpWrite           = 1'b0;
    localparam logic OpGenerate        = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_cmd;

    // Gain of each attenuation level, 0 dB down to silent.
    function automatic logic [14:0] atten_gain(input logic [3:0] att);
        logic [14:0] g;
        begin
            unique case (att)
                4'd0:  g = 15'd32767;
                4'd1:  g = 15'd26028;
                4'd2:  g = 15'd20675;
                4'd3:  g = 15'd16422;
                4'd4:  g = 15'd13045;
                4'd5:  g = 15'd10362;
                4'd6:  g = 15'd8231;
                4'd7:  g = 15'd6538;
                4'd8:  g = 15'd5197;
                4'd9:  g = 15'd4125;
                4'd10: g = 15'd3277;
                4'd11: g = 15'd2603;
                4'd12: g = 15'd2067;
                4'd13: g = 15'd1642;
                4'd14: g = 15'd1304;
                default: g = 15'd0;
            endcase
            return g;
        end
    endfunction

    // Level of one channel: floor(+-32767 * gain / 32768), in 16 bits signed.
    function automatic logic signed [15:0] weigh(input logic high, input logic [3:0] att);
        logic [29:0] p;
        logic [15:0] q;
        begin
            p = 30'(15'd32767) * 30'(atten_gain(att));
            if (high) begin
                q = {1'b0, p[29:15]};
            end else begin
                q = -({1'b0, p[29:15]} + {15'd0, (p[14:0] != 15'd0)});
            end
            return $signed(q);
        end
    endfunction

endpackage

FILE: rtl/core/psg_if.sv
// Valid/ready channel interfaces for commands, samples and the base register.
interface psg_cmd_if;
    logic              valid;
    logic              ready;
    psg_pkg::t_cmd     payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface psg_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [psg_pkg::SampleW-1:0]   sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface psg_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [psg_pkg::BaseW-1:0]      data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/psg_fifo.sv
// Short command queue between the front and back parts.
module psg_fifo #(
    parameter int unsigned DEPTH = psg_pkg::FifoDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  psg_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output psg_pkg::t_cmd o_cmd
);
    import psg_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule

FILE: rtl/core/psg_front.sv
// Front part: takes command words and the base register write.
module psg_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    psg_cmd_if.sink                    cmd,
    psg_cfg_if.sink                    cfg,
    input  logic                       i_full,
    output logic                       o_push,
    output psg_pkg::t_cmd              o_cmd,
    output logic [psg_pkg::BaseW-1:0]  o_base
);
    import psg_pkg::*;

    logic [BaseW-1:0] r_base;

    assign cmd.ready = !i_full;
    assign cfg.ready = 1'b1;
    assign o_push    = cmd.valid && !i_full;
    assign o_cmd     = cmd.payload;
    assign o_base    = r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BaseReset;
        end else if (cfg.valid) begin
            r_base <= cfg.data;
        end
    end
endmodule

FILE: rtl/core/psg_back.sv
// Back part: register decode, serial step division, sample generation.
module psg_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_empty,
    input  psg_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    input  logic [psg_pkg::BaseW-1:0]  i_base,
    psg_sample_if.source               smp
);
    import psg_pkg::*;

    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StDiv  = 3'd1;
    localparam logic [2:0] StNext = 3'd2;
    localparam logic [2:0] StOut  = 3'd3;

    logic [2:0]        r_state;
    logic [9:0]        r_period [3];
    logic [3:0]        r_att [4];
    logic [2:0]        r_latch;
    logic [StepW-1:0]  r_acc [4];
    logic [StepW-1:0]  r_step [4];
    logic              r_nout, r_white;
    logic [14:0]       r_lfsr;
    logic [1:0]        r_rate;
    logic [1:0]        r_ch;
    logic [5:0]        r_bit;
    logic [BaseW-1:0]  r_quo;
    logic [9:0]        r_rem;
    logic signed [SampleW-1:0] r_sample;
    logic              r_ovalid;

    logic [9:0]  w_div;
    logic [10:0] w_trial;
    logic [StepW-1:0] w_sum [4];
    logic        w_wrap, w_fb, w_nnext;
    logic [14:0] w_lfsr_n;
    logic signed [17:0] w_mix, w_clamp;
    logic signed [15:0] w_nw;

    assign smp.valid  = r_ovalid;
    assign smp.sample = r_sample;
    assign o_pop      = (r_state == StIdle) && !i_empty
                        && !(i_cmd.op == OpGenerate && r_ovalid && !smp.ready);

    // One quotient bit per cycle; divisor 1 acts as 2.
    assign w_div   = (r_period[r_ch] == 10'd1) ? 10'd2 : r_period[r_ch];
    assign w_trial = {r_rem, i_base[r_bit]} - {1'b0, w_div};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_sum[i] = r_acc[i] + r_step[i];
        end
        w_wrap   = r_acc[3][StepW-1] ^ w_sum[3][StepW-1];
        w_fb     = r_lfsr[14] ^ r_lfsr[13];
        w_lfsr_n = {r_lfsr[13:0], w_fb};
        w_nnext  = r_nout;
        if (w_wrap) begin
            w_nnext = r_white ? w_lfsr_n[0] : !r_nout;
        end
        w_nw  = weigh(w_nnext, r_att[3]);
        w_mix = 18'(weigh(w_sum[0][StepW-1], r_att[0]))
              + 18'(weigh(w_sum[1][StepW-1], r_att[1]))
              + 18'(weigh(w_sum[2][StepW-1], r_att[2]))
              + 18'(w_nw >>> 2);
        if (w_mix > 18'sd30000) begin
            w_clamp = 18'sd30000;
        end else if (w_mix < -18'sd30000) begin
            w_clamp = -18'sd30000;
        end else begin
            w_clamp = w_mix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= StIdle;
            r_latch  <= '0;
            r_nout   <= 1'b0;
            r_white  <= 1'b0;
            r_lfsr   <= LfsrSeed;
            r_rate   <= '0;
            r_ovalid <= 1'b0;
            r_ch     <= '0;
            r_bit    <= '0;
            for (int i = 0; i < 3; i++) r_period[i] <= '0;
            for (int i = 0; i < 4; i++) begin
                r_att[i]  <= 4'd15;
                r_acc[i]  <= '0;
                r_step[i] <= '0;
            end
        end else begin
            if (o_pop && i_cmd.op == OpGenerate) begin
                r_ovalid <= 1'b1;
            end else if (smp.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                StIdle: begin
                    if (o_pop) begin
                        if (i_cmd.op == OpGenerate) begin
                            for (int i = 0; i < 4; i++) r_acc[i] <= w_sum[i];
                            if (w_wrap && r_white) r_lfsr <= w_lfsr_n;
                            r_nout   <= w_nnext;
                            r_sample <= SampleW'(w_clamp >>> 5);
                        end else begin
                            if (i_cmd.data[7]) begin
                                r_latch <= i_cmd.data[6:4];
                                if (i_cmd.data[4]) begin
                                    r_att[i_cmd.data[6:5]] <= i_cmd.data[3:0];
                                end else if (i_cmd.data[6:5] == 2'd3) begin
                                    r_white <= i_cmd.data[2];
                                    r_rate  <= i_cmd.data[1:0];
                                    r_lfsr  <= LfsrSeed;
                                    r_nout  <= 1'b0;
                                end else begin
                                    r_period[i_cmd.data[6:5]][3:0] <= i_cmd.data[3:0];
                                end
                            end else if (!r_latch[0] && r_latch[2:1] != 2'd3) begin
                                r_period[r_latch[2:1]][9:4] <= i_cmd.data[5:0];
                            end
                            r_ch    <= '0;
                            r_state <= StNext;
                        end
                    end
                end
                StNext: begin
                    if (r_ch == 2'd3) begin
                        unique case (r_rate)
                            2'd0: r_step[3] <= i_base[BaseW-1:4];
                            2'd1: r_step[3] <= {1'b0, i_base[BaseW-1:5]};
                            2'd2: r_step[3] <= {2'b0, i_base[BaseW-1:6]};
                            default: r_step[3] <= r_step[2];
                        endcase
                        r_state <= StIdle;
                    end else if (r_period[r_ch] == '0) begin
                        r_step[r_ch] <= '0;
                        r_ch <= r_ch + 1'b1;
                    end else begin
                        r_rem   <= '0;
                        r_bit   <= 6'(BaseW-1);
                        r_state <= StDiv;
                    end
                end
                StDiv: begin
                    // Remainder stays below the divisor, so 10 bits hold it.
                    if (!w_trial[10]) begin
                        r_rem <= w_trial[9:0];
                        r_quo <= {r_quo[BaseW-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[8:0], i_base[r_bit]};
                        r_quo <= {r_quo[BaseW-2:0], 1'b0};
                    end
                    if (r_bit == '0) r_state <= StOut;
                    else r_bit <= r_bit - 1'b1;
                end
                StOut: begin
                    r_step[r_ch] <= r_quo[StepW-1:0];
                    r_ch    <= r_ch + 1'b1;
                    r_state <= StNext;
                end
                default: r_state <= StIdle;
            endcase
        end
    end
endmodule

FILE: rtl/core/psg_tone_noise_generator_top.sv
// Top level of the three-tone, one-noise sound generator.
// Usage:
// The cmd channel carries words of op and data. op write decodes a command
// byte; op generate advances all phase accumulators and yields one sample
// word on the smp channel. The cfg channel loads the 36-bit phase base,
// which takes effect at the next byte write; it is always ready.
// Words pass a four-entry queue to the back part, so the front keeps taking
// words while the back is busy.
// A generate word is handled while the back part is idle; the sample
// appears the next cycle and is held in an output register until taken.
// A write word is decoded first; then the three tone steps are found by a
// restoring divider, one quotient bit per cycle over 36 bits per channel,
// and last the noise step is set. The back part takes no new word meanwhile.
// A channel with period zero skips its division.
// When the receiver stalls, the next generate waits until the held sample
// is taken; the queue then fills and cmd ready drops.
// Reset clears periods, sets attenuations silent, seeds the noise register
// and loads the default phase base.
module psg_tone_noise_generator_top (
    input logic          i_clk,
    input logic          i_rst_n,
    psg_cmd_if.sink      cmd,
    psg_cfg_if.sink      cfg,
    psg_sample_if.source smp
);
    import psg_pkg::*;

    logic             w_push, w_full, w_pop, w_empty;
    t_cmd             w_in, w_out;
    logic [BaseW-1:0] w_base;

    psg_front u_front (
        .i_clk, .i_rst_n, .cmd, .cfg,
        .i_full(w_full), .o_push(w_push), .o_cmd(w_in), .o_base(w_base)
    );

    psg_fifo #(.DEPTH(FifoDepth)) u_fifo (
        .i_clk, .i_rst_n,
        .i_push(w_push), .i_cmd(w_in), .o_full(w_full),
        .i_pop(w_pop), .o_empty(w_empty), .o_cmd(w_out)
    );

    psg_back u_back (
        .i_clk, .i_rst_n,
        .i_empty(w_empty), .i_cmd(w_out), .o_pop(w_pop),
        .i_base(w_base), .smp
    );
endmodule
